@@ rtl/core/c32c_pkg.sv @@
// ----------------------------------------------------------------------------
// c32c_pkg
// Shared types, constants and the starting operator for the CRC-32 combine
// unit (reflected polynomial, GF(2) operator matrices held as column words).
// ----------------------------------------------------------------------------
package c32c_pkg;

    localparam int CRC_W = 32;
    localparam int IDX_W = $clog2(CRC_W);
    localparam int LEN_W = 64;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

    typedef logic [CRC_W-1:0] word_t;
    typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;
    typedef logic [CRC_W-2:0][CRC_W-1:0] part_mat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_APPLY
    } state_t;

    function automatic mat_t zero_bit_op();
        mat_t m;
        m[0] = CRC_POLY;
        for (int k = 1; k < CRC_W; k++)
        begin
            m[k] = word_t'(1) << (k - 1);
        end
        return m;
    endfunction

endpackage

@@ rtl/core/crc32_combine_unit.sv @@
// ----------------------------------------------------------------------------
// crc32_combine_unit
// Joins two finished CRC-32 values into the CRC-32 of the concatenated data.
// A zero length returns crc_first with the result strobe in the next cycle; else the
// operator is squared and applied per length bit up to the highest set bit.
// Throughput: one word at a time; busy stays high until the result strobe.
// Cost is set by the shared matrix-vector unit: 32 uses per squaring, 1 per apply.
// Reset clears the sequencer and the result strobe; no results are held off.
// ----------------------------------------------------------------------------
module crc32_combine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [c32c_pkg::CRC_W-1:0]    crc_first,
    input  logic [c32c_pkg::CRC_W-1:0]    crc_second,
    input  logic [c32c_pkg::LEN_W-1:0]    second_length,
    output logic                          done,
    output logic [c32c_pkg::CRC_W-1:0]    crc_joined
);
    import c32c_pkg::*;

    localparam mat_t ZERO_BIT_OP = zero_bit_op();

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [1:0]        pre_reg, pre_next;
    logic              done_reg, done_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    word_t             acc_reg, acc_next;
    word_t             tail_reg, tail_next;
    word_t             crc_joined_reg, crc_joined_next;
    mat_t              cur_reg, cur_next;
    part_mat_t         nxt_reg, nxt_next;
    word_t             vec;
    word_t             apply_res;

    c32c_gf2_apply u_gf2_apply (
        .mat (cur_reg),
        .vec (vec),
        .res (apply_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            pre_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            pre_reg   <= pre_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        acc_reg        <= acc_next;
        tail_reg       <= tail_next;
        crc_joined_reg <= crc_joined_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        pre_next        = pre_reg;
        done_next       = 1'b0;
        len_next        = len_reg;
        acc_next        = acc_reg;
        tail_next       = tail_reg;
        crc_joined_next = crc_joined_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        vec             = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next  = crc_first;
                    tail_next = crc_second;
                    len_next  = second_length;
                    cur_next  = ZERO_BIT_OP;
                    col_next  = '0;
                    pre_next  = 2'd2;
                    if (second_length == '0)
                    begin
                        crc_joined_next = crc_first;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                vec = cur_reg[col_reg];
                if (col_reg == IDX_W'(CRC_W - 1))
                begin
                    for (int k = 0; k < CRC_W - 1; k++)
                    begin
                        cur_next[k] = nxt_reg[k];
                    end
                    cur_next[CRC_W-1] = apply_res;
                    col_next          = '0;
                    if (pre_reg != 2'd0)
                    begin
                        pre_next = pre_reg - 2'd1;
                    end
                    else
                    begin
                        state_next = ST_APPLY;
                    end
                end
                else
                begin
                    nxt_next[col_reg] = apply_res;
                    col_next          = col_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                vec = acc_reg;
                if (len_reg[0])
                begin
                    acc_next = apply_res;
                end
                len_next = len_reg >> 1;
                if (len_reg[LEN_W-1:1] == '0)
                begin
                    crc_joined_next = (len_reg[0] ? apply_res : acc_reg) ^ tail_reg;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign crc_joined = crc_joined_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && second_length == '0) |=>
            (done && !busy && crc_joined == $past(crc_first)))
        else $error("zero length must return first crc next cycle");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE && col_reg != IDX_W'(CRC_W - 1)) |=>
            (state_reg == ST_SQUARE && col_reg == IDX_W'($past(col_reg) + 1'b1)))
        else $error("squaring column counter skipped");

    a_apply_from_square: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_APPLY) |->
            ($past(state_reg) == ST_SQUARE && $past(col_reg) == IDX_W'(CRC_W - 1)))
        else $error("apply entered before squaring finished");

endmodule

@@ rtl/core/c32c_gf2_apply.sv @@
// ----------------------------------------------------------------------------
// c32c_gf2_apply
// GF(2) matrix-vector product: XOR of the matrix columns selected by the set
// bits of the vector. Shared for both squaring and applying the operator.
// ----------------------------------------------------------------------------
module c32c_gf2_apply (
    input  c32c_pkg::mat_t  mat,
    input  c32c_pkg::word_t vec,
    output c32c_pkg::word_t res
);
    import c32c_pkg::*;

    always_comb
    begin
        res = '0;
        for (int k = 0; k < CRC_W; k++)
        begin
            if (vec[k])
            begin
                res = res ^ mat[k];
            end
        end
    end

endmodule
